### sv/dpfc_pkg.sv
// Package for the dual-loop PID force controller: shared types, codes and constants.
// Used by dpfc_mul, dpfc_div and dual_pid_force_controller; depends on nothing.
`timescale 1ns / 1ps

package dpfc_pkg;

  // Field widths
  localparam int GAIN_W  = 24;
  localparam int DT_W    = 16;
  localparam int CODE_W  = 16;
  localparam int ERR_W   = 17;
  localparam int INTEG_W = 48;
  localparam int PROD_W  = 42;
  localparam int ACC_W   = 64;
  localparam int QUOT_W  = 33;
  localparam int COST_W  = 39;
  localparam int FORCE_W = 15;
  localparam int SEQ_W   = 8;
  localparam int IDX_IN_W = 4;
  localparam int CNT_W   = 8;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CART_KP = 3'd0;
  localparam logic [2:0] REG_CART_KI = 3'd1;
  localparam logic [2:0] REG_CART_KD = 3'd2;
  localparam logic [2:0] REG_POLE_KP = 3'd3;
  localparam logic [2:0] REG_POLE_KI = 3'd4;
  localparam logic [2:0] REG_POLE_KD = 3'd5;
  localparam logic [2:0] REG_STEP_DT = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0] RST_CART_KP = 24'd3148824;
  localparam logic [GAIN_W-1:0] RST_CART_KI = 24'd3641672;
  localparam logic [GAIN_W-1:0] RST_CART_KD = 24'd2251817;
  localparam logic [GAIN_W-1:0] RST_POLE_KP = 24'd9920184;
  localparam logic [GAIN_W-1:0] RST_POLE_KI = 24'd3590390;
  localparam logic [GAIN_W-1:0] RST_POLE_KD = 24'd163840;
  localparam logic [DT_W-1:0]   RST_STEP_DT = 16'd1311;

  // Report decoding
  localparam logic [ERR_W-1:0] CODE_OFFSET = 17'd10000;
  localparam logic [CNT_W-1:0] WORDS_EXPECTED = 8'd4;

  // Force limit on (pole output - cart output), Q.14, and the code bias
  localparam logic signed [ACC_W-1:0] DIFF_LIMIT = 64'sd16384000;
  localparam logic signed [29:0]      FORCE_BIAS = 30'sd163840000;

  // Sequencer steps within one report
  localparam logic [3:0] S_EDT   = 4'd0;   // error * dt into the integral
  localparam logic [3:0] S_KP    = 4'd1;   // kp * error
  localparam logic [3:0] S_KILO  = 4'd2;   // ki * integral low 16 bits, floored
  localparam logic [3:0] S_KIHL  = 4'd3;   // ki * integral bits 31:16
  localparam logic [3:0] S_KIHH  = 4'd4;   // ki * integral bits 47:32
  localparam logic [3:0] S_KD0   = 4'd5;   // kd * derivative bits 15:0
  localparam logic [3:0] S_KD1   = 4'd6;   // kd * derivative bits 31:16
  localparam logic [3:0] S_KD2   = 4'd7;   // kd * derivative sign
  localparam logic [3:0] S_CX    = 4'd8;   // x * x into the cost
  localparam logic [3:0] S_CT    = 4'd9;   // 100 theta * theta into the cost
  localparam logic [3:0] S_DRAIN = 4'd10;  // let the last product land

  // Where a product goes and how it is weighted
  localparam logic [2:0] DST_INTEG   = 3'd0;
  localparam logic [2:0] DST_SH0     = 3'd1;
  localparam logic [2:0] DST_SH16    = 3'd2;
  localparam logic [2:0] DST_SH32    = 3'd3;
  localparam logic [2:0] DST_FLOOR16 = 3'd4;
  localparam logic [2:0] DST_COST    = 3'd5;

  // Tag that travels with each multiply request
  typedef struct packed {
    logic       valid;
    logic [2:0] dst;
    logic       pole;
  } mul_tag_t;

endpackage

### sv/dpfc_mul.sv
// Shared multiplier: unsigned 24-bit gain by signed 17-bit operand, registered product.
// Depends on dpfc_pkg for widths and the request tag.
`timescale 1ns / 1ps

module dpfc_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [dpfc_pkg::GAIN_W-1:0]           op_a,
  input  logic signed [dpfc_pkg::ERR_W-1:0]     op_b,
  input  dpfc_pkg::mul_tag_t                    tag_in,
  output logic signed [dpfc_pkg::PROD_W-1:0]    prod,
  output dpfc_pkg::mul_tag_t                    tag_out
);
  import dpfc_pkg::*;

  logic signed [GAIN_W:0] a_s;

  assign a_s = $signed({1'b0, op_a});

  // Register product and its tag
  always_ff @(posedge clk) begin
    prod <= a_s * op_b;
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule

### sv/dpfc_div.sv
// Restoring divider, one quotient bit per cycle: (delta * 65536) / dt, truncated to zero.
// Depends on dpfc_pkg for widths.
`timescale 1ns / 1ps

module dpfc_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [dpfc_pkg::ERR_W:0]      delta,
  input  logic [dpfc_pkg::DT_W-1:0]            divisor,
  output logic                                 busy,
  output logic signed [dpfc_pkg::QUOT_W-1:0]   quot
);
  import dpfc_pkg::*;

  logic [31:0]     dvd;
  logic [DT_W-1:0] rem;
  logic [DT_W-1:0] dvs;
  logic [5:0]      cnt;
  logic            neg;
  logic [ERR_W:0]  mag;
  logic [DT_W:0]   shifted;
  logic            fits;

  assign mag     = delta[ERR_W] ? 18'(-delta) : 18'(delta);
  assign shifted = {rem, dvd[31]};
  assign fits    = shifted >= {1'b0, dvs};
  assign busy    = cnt != 6'd0;
  assign quot    = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

  // Load operands, then shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
    if (start) begin
      dvd <= {mag[DT_W-1:0], 16'd0};
      rem <= '0;
      dvs <= divisor;
      neg <= delta[ERR_W];
    end else if (busy) begin
      rem <= fits ? DT_W'(shifted - {1'b0, dvs}) : shifted[DT_W-1:0];
      dvd <= {dvd[30:0], fits};
    end
  end

endmodule

### sv/dual_pid_force_controller.sv
// Channel   | Dir | Payload (lowest bits first)                                | Handshake
// s_        | in  | tuser: source_known; tdata: index, count, position, angle | tvalid/tready
// m_        | out | tdata: dest_index, sequence_res, force_code, cost_micro   | tvalid/tready
// cfg_      | in  | cfg_index selects register, cfg_data holds value         | cfg_we only
//
// For a valid report, each loop runs one divider pass for its derivative, with the
// other multiplies of the loop overlapped, and the shared multiplier issues one
// request per cycle otherwise. A dropped report frees the input from the check
// state. Reset is synchronous and clears the integrals, last errors and sequence
// valid bits at once. A stalled result is held in the output register; the next
// report is accepted meanwhile.
// Depends on dpfc_pkg, dpfc_mul and dpfc_div.
`timescale 1ns / 1ps

module dual_pid_force_controller #(
  parameter int NUM_DESTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // source_index[3:0], word_count[11:4],
                                 // position_code[27:12], angle_code[43:28]
  input  logic        s_tuser,   // source_known
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // dest_index[3:0], sequence_res[11:4],
                                 // force_code[26:12], cost_micro[65:27]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import dpfc_pkg::*;

  localparam int IDX_W = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;

  logic [2:0] state;
  logic [3:0] step;
  logic       pole;

  // Configuration registers
  logic [GAIN_W-1:0] cart_kp, cart_ki, cart_kd, pole_kp, pole_ki, pole_kd;
  logic [DT_W-1:0]   step_time;
  logic [DT_W-1:0]   dt_eff;

  // Captured report
  logic                  rpt_known;
  logic [IDX_IN_W-1:0]   rpt_idx;
  logic [CNT_W-1:0]      rpt_count;
  logic signed [ERR_W-1:0] e_cart, e_pole;

  // Loop state
  logic signed [INTEG_W-1:0] cart_integ, pole_integ;
  logic signed [ERR_W-1:0]   cart_last, pole_last;
  logic signed [ACC_W-1:0]   acc;
  logic [COST_W-1:0]         cost;

  // Sequence counters
  logic [SEQ_W-1:0]     seq_mem [NUM_DESTS];
  logic [NUM_DESTS-1:0] seq_valid;
  logic [SEQ_W-1:0]     seq_rd;
  logic                 seq_vld_rd;
  logic [SEQ_W-1:0]     seq_cur;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 seq_we;

  // Multiplier and divider hookup
  logic [GAIN_W-1:0]         op_a;
  logic signed [ERR_W-1:0]   op_b;
  mul_tag_t                  tag_in, ptag;
  logic signed [PROD_W-1:0]  prod;
  logic                      div_start, div_busy;
  logic signed [QUOT_W-1:0]  quot;
  logic signed [ERR_W:0]     delta;

  // Per-loop selections
  logic signed [ERR_W-1:0]   cur_e, cur_last;
  logic signed [INTEG_W-1:0] cur_integ;
  logic [GAIN_W-1:0]         cur_kp, cur_ki, cur_kd;
  logic [ERR_W-1:0]          abs_c_full, abs_p_full;
  logic [CODE_W-1:0]         abs_c, abs_p;
  logic [GAIN_W-1:0]         hund_p;
  logic                      is_kd, stall, advance, reject, in_acc, fin_go;

  // Product consumers
  logic signed [ACC_W-1:0]   prod64, term;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat, prod_integ;

  // Result shaping
  logic signed [25:0]        diff_c;
  logic signed [29:0]        num;
  logic [FORCE_W-1:0]        force_code;

  assign s_tready = state == ST_IDLE;
  assign in_acc   = s_tvalid && s_tready;
  assign dt_eff   = (step_time == '0) ? DT_W'(1) : step_time;

  assign cur_e     = pole ? e_pole : e_cart;
  assign cur_last  = pole ? pole_last : cart_last;
  assign cur_integ = pole ? pole_integ : cart_integ;
  assign cur_kp    = pole ? pole_kp : cart_kp;
  assign cur_ki    = pole ? pole_ki : cart_ki;
  assign cur_kd    = pole ? pole_kd : cart_kd;
  assign delta     = 18'(cur_e) - 18'(cur_last);

  assign abs_c_full = e_cart[ERR_W-1] ? ERR_W'(-e_cart) : ERR_W'(e_cart);
  assign abs_p_full = e_pole[ERR_W-1] ? ERR_W'(-e_pole) : ERR_W'(e_pole);
  assign abs_c      = abs_c_full[CODE_W-1:0];
  assign abs_p      = abs_p_full[CODE_W-1:0];
  assign hund_p     = (GAIN_W'(abs_p) << 6) + (GAIN_W'(abs_p) << 5) + (GAIN_W'(abs_p) << 2);

  assign is_kd   = (step == S_KD0) || (step == S_KD1) || (step == S_KD2);
  assign stall   = is_kd && div_busy;
  assign advance = (state == ST_RUN) && !stall;
  assign div_start = advance && (step == S_EDT);

  assign reject = !rpt_known || ({{(32-IDX_IN_W){1'b0}}, rpt_idx} >= 32'(NUM_DESTS))
                  || (rpt_count != WORDS_EXPECTED);

  assign rd_addr = IDX_W'(s_tdata[3:0]);
  assign wr_addr = IDX_W'(rpt_idx);
  assign fin_go  = (state == ST_FIN) && (!m_tvalid || m_tready);
  assign seq_we  = fin_go;

  // Select operands for the current step
  always_comb begin
    op_a         = '0;
    op_b         = '0;
    tag_in.valid = advance && (step != S_DRAIN);
    tag_in.dst   = DST_COST;
    tag_in.pole  = pole;
    case (step)
      S_EDT: begin
        op_a = GAIN_W'(dt_eff);
        op_b = cur_e;
        tag_in.dst = DST_INTEG;
      end
      S_KP: begin
        op_a = cur_kp;
        op_b = cur_e;
        tag_in.dst = DST_SH0;
      end
      S_KILO: begin
        op_a = cur_ki;
        op_b = $signed({1'b0, cur_integ[15:0]});
        tag_in.dst = DST_FLOOR16;
      end
      S_KIHL: begin
        op_a = cur_ki;
        op_b = $signed({1'b0, cur_integ[31:16]});
        tag_in.dst = DST_SH0;
      end
      S_KIHH: begin
        op_a = cur_ki;
        op_b = $signed({cur_integ[47], cur_integ[47:32]});
        tag_in.dst = DST_SH16;
      end
      S_KD0: begin
        op_a = cur_kd;
        op_b = $signed({1'b0, quot[15:0]});
        tag_in.dst = DST_SH0;
      end
      S_KD1: begin
        op_a = cur_kd;
        op_b = $signed({1'b0, quot[31:16]});
        tag_in.dst = DST_SH16;
      end
      S_KD2: begin
        op_a = cur_kd;
        op_b = $signed({ERR_W{quot[QUOT_W-1]}});
        tag_in.dst = DST_SH32;
      end
      S_CX: begin
        op_a = GAIN_W'(abs_c);
        op_b = $signed({1'b0, abs_c});
      end
      S_CT: begin
        op_a = hund_p;
        op_b = $signed({1'b0, abs_p});
      end
      default: begin
        tag_in.valid = 1'b0;
      end
    endcase
  end

  dpfc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .op_a    (op_a),
    .op_b    (op_b),
    .tag_in  (tag_in),
    .prod    (prod),
    .tag_out (ptag)
  );

  dpfc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .delta   (delta),
    .divisor (dt_eff),
    .busy    (div_busy),
    .quot    (quot)
  );

  // Weight the product for the force accumulator
  assign prod64 = ACC_W'(prod);
  always_comb begin
    case (ptag.dst)
      DST_SH16:    term = prod64 <<< 16;
      DST_SH32:    term = prod64 <<< 32;
      DST_FLOOR16: term = prod64 >>> 16;
      default:     term = prod64;
    endcase
  end

  // Saturating integral update
  assign prod_integ = ptag.pole ? pole_integ : cart_integ;
  assign integ_sum  = (INTEG_W+1)'(prod_integ) + (INTEG_W+1)'(prod);
  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
  end

  // Clamp the loop difference and code the force
  always_comb begin
    if (acc > DIFF_LIMIT) begin
      diff_c = 26'(DIFF_LIMIT);
    end else if (acc < -DIFF_LIMIT) begin
      diff_c = 26'(-DIFF_LIMIT);
    end else begin
      diff_c = acc[25:0];
    end
    num        = FORCE_BIAS - (30'(diff_c) <<< 3) - (30'(diff_c) <<< 1);
    force_code = num[28:14];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cart_kp   <= RST_CART_KP;
      cart_ki   <= RST_CART_KI;
      cart_kd   <= RST_CART_KD;
      pole_kp   <= RST_POLE_KP;
      pole_ki   <= RST_POLE_KI;
      pole_kd   <= RST_POLE_KD;
      step_time <= RST_STEP_DT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CART_KP: cart_kp   <= cfg_data;
        REG_CART_KI: cart_ki   <= cfg_data;
        REG_CART_KD: cart_kd   <= cfg_data;
        REG_POLE_KP: pole_kp   <= cfg_data;
        REG_POLE_KI: pole_ki   <= cfg_data;
        REG_POLE_KD: pole_kd   <= cfg_data;
        REG_STEP_DT: step_time <= cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the report
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rpt_known <= s_tuser;
      rpt_idx   <= s_tdata[3:0];
      rpt_count <= s_tdata[11:4];
      e_cart    <= $signed(CODE_OFFSET - {1'b0, s_tdata[27:12]});
      e_pole    <= $signed(CODE_OFFSET - {1'b0, s_tdata[43:28]});
    end
    if (state == ST_CHECK) begin
      seq_cur <= seq_vld_rd ? seq_rd : '0;
    end
  end

  // Sequence counter memory
  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[wr_addr] <= seq_cur + SEQ_W'(1);
    end
    if (in_acc) begin
      seq_rd <= seq_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid  <= '0;
      seq_vld_rd <= 1'b0;
    end else begin
      if (seq_we) begin
        seq_valid[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        seq_vld_rd <= seq_valid[rd_addr];
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= S_EDT;
      pole  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          step  <= S_EDT;
          pole  <= 1'b0;
          state <= reject ? ST_IDLE : ST_RUN;
        end
        ST_RUN: begin
          if (advance) begin
            case (step)
              S_KD2: begin
                if (pole) begin
                  step <= S_CX;
                end else begin
                  pole <= 1'b1;
                  step <= S_EDT;
                end
              end
              S_DRAIN: state <= ST_FIN;
              default: step <= step + 4'd1;
            endcase
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Last error: take the new error as the divider starts
  always_ff @(posedge clk) begin
    if (rst) begin
      cart_last <= '0;
      pole_last <= '0;
    end else if (div_start) begin
      if (pole) begin
        pole_last <= e_pole;
      end else begin
        cart_last <= e_cart;
      end
    end
  end

  // Land products: integrals, force accumulator, cost
  always_ff @(posedge clk) begin
    if (rst) begin
      cart_integ <= '0;
      pole_integ <= '0;
    end else if (ptag.valid && (ptag.dst == DST_INTEG)) begin
      if (ptag.pole) begin
        pole_integ <= integ_sat;
      end else begin
        cart_integ <= integ_sat;
      end
    end
    if (state == ST_CHECK) begin
      acc  <= '0;
      cost <= '0;
    end else if (ptag.valid) begin
      case (ptag.dst)
        DST_INTEG: ;
        DST_COST:  cost <= cost + prod[COST_W-1:0];
        default:   acc  <= ptag.pole ? acc + term : acc - term;
      endcase
    end
  end

  // Output register: hold until taken, load when the result is done
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (fin_go) begin
      m_tdata <= {6'd0, cost, force_code, seq_cur, rpt_idx};
    end
  end

endmodule

### sv/dpfc_checker.sv
// Port-level checks for dual_pid_force_controller, attached by the bind below.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module dpfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // Force code stays within the saturated range
  a_force_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[26:12] <= 15'd20000)
    else $error("force code beyond 20000");

  // Drop ready for at least the cycle after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted request");

  // A new result only appears while the input side is busy
  a_result_when_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

  // Output is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind dual_pid_force_controller dpfc_checker u_dpfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/dual_pid_force_controller_tb.sv
// Testbench for dual_pid_force_controller: sends sensor report requests, predicts each
// force update with an untimed copy of both PID loops and checks every result in order.
// Depends on dpfc_pkg and the controller RTL.
`timescale 1ns / 1ps

module dual_pid_force_controller_tb;
  import dpfc_pkg::*;

  localparam int NUM_DESTS     = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 100;   // covers a report still in flight
  localparam int CART          = 0;
  localparam int POLE          = 1;
  localparam logic [2:0] REG_SPARE = 3'd7;  // no register behind this index
  localparam longint INTEG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;

  typedef struct packed {
    logic        source_known;
    logic [3:0]  source_index;
    logic [7:0]  word_count;
    logic [15:0] position_code;
    logic [15:0] angle_code;
  } report_t;

  typedef struct packed {
    logic [3:0]  dest_index;
    logic [7:0]  sequence_res;
    logic [14:0] force_code;
    logic [38:0] cost_micro;
  } force_update_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // source_index[3:0], word_count[11:4],
                          // position_code[27:12], angle_code[43:28]
  logic        s_tuser;   // source_known
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // dest_index[3:0], sequence_res[11:4],
                          // force_code[26:12], cost_micro[65:27]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  // Predicted controller state and settings
  longint        gain_q14 [6];
  longint        step_dt;
  longint        loop_integ [2];
  longint        loop_prev_err [2];
  logic [7:0]    seq_next [NUM_DESTS];
  force_update_t updates_due [$];
  force_update_t oldest_update;

  int mismatches        = 0;
  int send_idle_pct     = 0;
  int recv_idle_pct     = 0;
  int cycle_count       = 0;

  dual_pid_force_controller #(
    .NUM_DESTS(NUM_DESTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic reset_predictor();
    gain_q14[REG_CART_KP] = longint'(RST_CART_KP);
    gain_q14[REG_CART_KI] = longint'(RST_CART_KI);
    gain_q14[REG_CART_KD] = longint'(RST_CART_KD);
    gain_q14[REG_POLE_KP] = longint'(RST_POLE_KP);
    gain_q14[REG_POLE_KI] = longint'(RST_POLE_KI);
    gain_q14[REG_POLE_KD] = longint'(RST_POLE_KD);
    step_dt = longint'(RST_STEP_DT);
    for (int l = CART; l <= POLE; l++) begin
      loop_integ[l] = 0;
      loop_prev_err[l] = 0;
    end
    for (int d = 0; d < NUM_DESTS; d++) seq_next[d] = 8'd0;
  endtask

  // One PID loop: advance its integral and last error, return the output in Q.14
  function automatic longint loop_output(input int l, input longint err, input longint dt);
    longint acc;
    longint deriv;
    longint lo;
    longint hi;
    longint kp;
    longint ki;
    longint kd;
    kp = gain_q14[3 * l];
    ki = gain_q14[3 * l + 1];
    kd = gain_q14[3 * l + 2];
    acc = loop_integ[l] + err * dt;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    else if (acc < INTEG_MIN) acc = INTEG_MIN;
    loop_integ[l] = acc;
    deriv = (err - loop_prev_err[l]) * 65536 / dt;
    loop_prev_err[l] = err;
    // split the integral so the floor of ki*I/2^16 comes out exact
    lo = acc & 64'hFFFF;
    hi = (acc - lo) / 65536;
    return kp * err + ki * hi + (ki * lo) / 65536 + kd * deriv;
  endfunction

  // Queue the force update an accepted report causes, if any
  function automatic void predict_force_update(input report_t r);
    longint x;
    longint th;
    longint dt;
    longint u_cart;
    longint u_pole;
    longint diff;
    longint num;
    longint cost;
    logic [63:0] code_q;
    logic [63:0] cost_bits;
    force_update_t upd;
    if (!r.source_known || r.source_index >= NUM_DESTS || r.word_count != WORDS_EXPECTED)
      return;
    dt = (step_dt == 0) ? 64'sd1 : step_dt;
    x = longint'(r.position_code) - longint'(CODE_OFFSET);
    th = longint'(r.angle_code) - longint'(CODE_OFFSET);
    u_cart = loop_output(CART, -x, dt);
    u_pole = loop_output(POLE, -th, dt);
    diff = u_pole - u_cart;
    if (diff > DIFF_LIMIT) diff = DIFF_LIMIT;
    else if (diff < -DIFF_LIMIT) diff = -DIFF_LIMIT;
    num = FORCE_BIAS - 10 * diff;
    code_q = num / 16384;
    cost = x * x + 100 * th * th;
    cost_bits = cost;
    upd.dest_index = r.source_index;
    upd.sequence_res = seq_next[r.source_index];
    upd.force_code = code_q[14:0];
    upd.cost_micro = cost_bits[38:0];
    seq_next[r.source_index] = seq_next[r.source_index] + 8'd1;
    updates_due = {updates_due, upd};
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted force update with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (updates_due.size() == 0) begin
        $error("force update with none expected: dest_index %0d", m_tdata[3:0]);
        mismatches++;
      end else begin
        oldest_update = updates_due.pop_front();
        check_field("dest_index", 64'(oldest_update.dest_index), 64'(m_tdata[3:0]));
        check_field("sequence_res", 64'(oldest_update.sequence_res), 64'(m_tdata[11:4]));
        check_field("force_code", 64'(oldest_update.force_code), 64'(m_tdata[26:12]));
        check_field("cost_micro", 64'(oldest_update.cost_micro), 64'(m_tdata[65:27]));
      end
    end
  end

  // Drive one report request and hold it until accepted
  task automatic send_report(input report_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.source_known;
    s_tdata <= {4'd0, r.angle_code, r.position_code, r.word_count, r.source_index};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_force_update(r);
  endtask

  // Drop valid, drain every pending update, then cover a dropped report still in work
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (updates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (index == REG_STEP_DT) step_dt = longint'(value[15:0]);
    else if (index != REG_SPARE) gain_q14[index] = longint'(value);
  endtask

  task automatic write_all_gains(input logic [23:0] value);
    for (int i = REG_CART_KP; i <= REG_POLE_KD; i++) write_register(i[2:0], value);
  endtask

  function automatic report_t make_report(input logic known, input logic [3:0] idx,
                                          input logic [7:0] count, input logic [15:0] pos,
                                          input logic [15:0] ang);
    report_t r;
    r.source_known = known;
    r.source_index = idx;
    r.word_count = count;
    r.position_code = pos;
    r.angle_code = ang;
    return r;
  endfunction

  // Mostly near the setpoint, where the force is not saturated
  function automatic logic [15:0] random_code();
    logic [15:0] c;
    case ($urandom_range(2))
      0: c = 16'd9997 + 16'($urandom_range(6));
      1: c = 16'd9500 + 16'($urandom_range(1000));
      default: c = 16'($urandom_range(65535));
    endcase
    return c;
  endfunction

  function automatic report_t random_report();
    report_t r;
    r.source_known = 1'b1;
    r.word_count = WORDS_EXPECTED;
    // favor two sources so their sequence numbers wrap
    r.source_index = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(1));
    r.position_code = random_code();
    r.angle_code = random_code();
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(2))
        0: r.source_known = 1'b0;
        1: r.word_count = 8'($urandom_range(255));
        default: begin
          r.source_known = 1'($urandom_range(1));
          r.word_count = 8'($urandom_range(8));
        end
      endcase
    end
    return r;
  endfunction

  task automatic write_random_settings();
    logic [23:0] g;
    logic [15:0] dt;
    for (int i = REG_CART_KP; i <= REG_POLE_KD; i++) begin
      case ($urandom_range(2))
        0: g = 24'($urandom_range(24'hFFFFFF));
        1: g = 24'($urandom_range(16384));
        default: g = 24'($urandom_range(1 << 20));
      endcase
      write_register(i[2:0], g);
    end
    case ($urandom_range(2))
      0: dt = 16'($urandom_range(65535, 1));
      1: dt = 16'($urandom_range(2000, 1));
      default: dt = 16'd1;
    endcase
    write_register(REG_STEP_DT, {8'd0, dt});
  endtask

  // Reset gains, small errors around the setpoint
  task automatic test_register_defaults();
    send_report(make_report(1'b1, 4'd3, WORDS_EXPECTED, 16'd10000, 16'd10000));
    send_report(make_report(1'b1, 4'd3, WORDS_EXPECTED, 16'd10001, 16'd10000));
    send_report(make_report(1'b1, 4'd3, WORDS_EXPECTED, 16'd10000, 16'd9999));
    send_report(make_report(1'b1, 4'd3, WORDS_EXPECTED, 16'd10002, 16'd10001));
  endtask

  // Unknown source and bad word counts leave no trace; the next sequence number proves it
  task automatic test_dropped_reports();
    send_report(make_report(1'b0, 4'd3, WORDS_EXPECTED, 16'd12000, 16'd8000));
    send_report(make_report(1'b1, 4'd3, 8'd0, 16'd12000, 16'd8000));
    send_report(make_report(1'b1, 4'd3, 8'd3, 16'd12000, 16'd8000));
    send_report(make_report(1'b1, 4'd3, 8'd5, 16'd12000, 16'd8000));
    send_report(make_report(1'b1, 4'd3, 8'd255, 16'd12000, 16'd8000));
    send_report(make_report(1'b1, 4'd3, WORDS_EXPECTED, 16'd10001, 16'd10001));
  endtask

  // Code and index extremes, saturating the force both ways
  task automatic test_code_extremes();
    send_report(make_report(1'b1, 4'd0, WORDS_EXPECTED, 16'd0, 16'd0));
    send_report(make_report(1'b1, 4'd15, WORDS_EXPECTED, 16'd65535, 16'd65535));
    send_report(make_report(1'b1, 4'd15, WORDS_EXPECTED, 16'd0, 16'd65535));
    send_report(make_report(1'b1, 4'd0, WORDS_EXPECTED, 16'd65535, 16'd0));
  endtask

  // Largest gains with zero step time, zero gains with the longest step, spare index
  task automatic test_register_extremes();
    settle_idle();
    write_all_gains(24'hFFFFFF);
    write_register(REG_STEP_DT, 24'd0);
    send_report(make_report(1'b1, 4'd7, WORDS_EXPECTED, 16'd10001, 16'd9999));
    send_report(make_report(1'b1, 4'd7, WORDS_EXPECTED, 16'd0, 16'd65535));
    settle_idle();
    write_all_gains(24'd0);
    write_register(REG_STEP_DT, 24'd65535);
    send_report(make_report(1'b1, 4'd8, WORDS_EXPECTED, 16'd65535, 16'd0));
    send_report(make_report(1'b1, 4'd8, WORDS_EXPECTED, 16'd9990, 16'd10010));
    settle_idle();
    write_register(REG_SPARE, 24'h5A5A5A);
    write_register(REG_CART_KP, RST_CART_KP);
    write_register(REG_CART_KI, RST_CART_KI);
    write_register(REG_CART_KD, RST_CART_KD);
    write_register(REG_POLE_KP, RST_POLE_KP);
    write_register(REG_POLE_KI, RST_POLE_KI);
    write_register(REG_POLE_KD, RST_POLE_KD);
    write_register(REG_STEP_DT, {8'd0, RST_STEP_DT});
    send_report(make_report(1'b1, 4'd9, WORDS_EXPECTED, 16'd10003, 16'd9998));
  endtask

  // Random traffic under three random settings at the given idle rates
  task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                     input int reports);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    for (int s = 0; s < 3; s++) begin
      settle_idle();
      write_random_settings();
      for (int n = 0; n < reports / 3; n++) send_report(random_report());
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    m_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_CART_KP;
    cfg_data <= '0;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_dropped_reports();
    test_code_extremes();
    test_register_extremes();
    test_random_traffic(6, 62, 580);
    test_random_traffic(62, 6, 580);
    test_random_traffic(0, 0, 590);

    settle_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### dual_pid_force_controller.f
sv/dpfc_pkg.sv
sv/dpfc_mul.sv
sv/dpfc_div.sv
sv/dual_pid_force_controller.sv
sv/dpfc_checker.sv
tb/sv/dual_pid_force_controller_tb.sv
